### rtl/bilinear_upsampler_4x_core_assert.svh
// Assertion macros for the bilinear upsampler RTL.
`ifndef BILINEAR_UPSAMPLER_4X_CORE_ASSERT_SVH
`define BILINEAR_UPSAMPLER_4X_CORE_ASSERT_SVH

// Check that the condition implies the consequence in the same cycle.
`define BU4X_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Check that the condition implies the consequence in the next cycle.
`define BU4X_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/bu4x_pkg.sv
// Constants and types of the bilinear 4x upsampler.
`default_nettype none
package bu4x_pkg;

	// Field widths
	localparam int COORD_W  = 10;
	localparam int HEIGHT_W = 13;

	// Grid geometry
	localparam int LOW_SIZE_DEF  = 257;
	localparam int WINDOW_ORIGIN = 64;
	localparam int UP_LOG2       = 2;
	localparam int UPSCALE       = 1 << UP_LOG2;

	// Arithmetic widths
	localparam int EXT_W = COORD_W + 1;
	localparam int FU_W  = UP_LOG2 + 1;
	localparam int WT_W  = 2 * UP_LOG2 + 1;
	localparam int ACC_W = HEIGHT_W + 2 * UP_LOG2;

	// Neighbor sequencing
	localparam int NBR_W = 2;
	localparam logic [NBR_W-1:0] NBR_LAST = 2'd3;

	// Operation codes
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Control bits that travel with one grid access
	typedef struct packed {
		logic vld;
		logic last;
		logic query;
		logic wr;
	} stg_t;

endpackage
`default_nettype wire

### rtl/bilinear_upsampler_4x_core.sv
// Top level of the bilinear 4x upsampler: grid memory, neighbor sequencer, accumulator.
//
//   channel | handshake           | payload
//   --------+---------------------+--------------------------------------------
//   in      | in_valid / in_stall | operation, row, col, sample_height
//   out     | out_valid/out_stall | interpolated_height
//
// A load word occupies the core from its accept until its grid write has left
// the pipeline. A query word occupies it while four neighbor addresses are
// issued in turn to the single read port of the grid RAM, each followed by a
// read and a multiply-accumulate stage; the result lands in the output register.
// The grid RAM holds no reset; cells read before being loaded return anything.
// A result waiting on out_stall does not block the next accept; a following
// query holds in its last stage until the output register frees.
`default_nettype none
`include "bilinear_upsampler_4x_core_assert.svh"
module bilinear_upsampler_4x_core #(
	parameter int LOW_SIZE = bu4x_pkg::LOW_SIZE_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output      logic                          in_stall,
	input  wire logic                          operation,
	input  wire logic [bu4x_pkg::COORD_W-1:0]  row,
	input  wire logic [bu4x_pkg::COORD_W-1:0]  col,
	input  wire logic [bu4x_pkg::HEIGHT_W-1:0] sample_height,
	output      logic                          out_valid,
	input  wire logic                          out_stall,
	output      logic [bu4x_pkg::HEIGHT_W-1:0] interpolated_height
);

	import bu4x_pkg::*;

	localparam int IDX_W  = $clog2(LOW_SIZE);
	localparam int DEPTH  = LOW_SIZE * LOW_SIZE;
	localparam int ADDR_W = $clog2(DEPTH);

	// Saturate a grid index at the last row or column
	function automatic logic [IDX_W-1:0] clamp_idx(input logic [EXT_W-1:0] v);
		logic [EXT_W-1:0] c;
		c = (v >= EXT_W'(LOW_SIZE)) ? EXT_W'(LOW_SIZE - 1) : v;
		return c[IDX_W-1:0];
	endfunction

	// Accept and busy
	logic busy_q;
	logic in_acc;
	logic hold;
	logic fin;

	assign in_stall = busy_q;
	assign in_acc   = in_valid && !busy_q;

	// Index decode at accept
	logic [EXT_W-1:0] row_e, col_e, r_base, c_base;
	logic [IDX_W-1:0] r0_d, r1_d, c0_d, c1_d;
	logic             ld_ok_d;

	always_comb begin
		row_e   = EXT_W'(row);
		col_e   = EXT_W'(col);
		r_base  = EXT_W'(row >> UP_LOG2) + EXT_W'(WINDOW_ORIGIN);
		c_base  = EXT_W'(col >> UP_LOG2) + EXT_W'(WINDOW_ORIGIN);
		ld_ok_d = (row_e < EXT_W'(LOW_SIZE)) && (col_e < EXT_W'(LOW_SIZE));
		if (operation == OP_QUERY) begin
			r0_d = clamp_idx(r_base);
			c0_d = clamp_idx(c_base);
		end else begin
			r0_d = row_e[IDX_W-1:0];
			c0_d = col_e[IDX_W-1:0];
		end
		r1_d = clamp_idx(r_base + EXT_W'(1));
		c1_d = clamp_idx(c_base + EXT_W'(1));
	end

	// Capture the accepted word
	logic                 query_q;
	logic                 ld_ok_q;
	logic [IDX_W-1:0]     r0_q, r1_q, c0_q, c1_q;
	logic [UP_LOG2-1:0]   fr_q, fc_q;
	logic [HEIGHT_W-1:0]  height_q;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			query_q  <= operation;
			ld_ok_q  <= ld_ok_d;
			r0_q     <= r0_d;
			r1_q     <= r1_d;
			c0_q     <= c0_d;
			c1_q     <= c1_d;
			fr_q     <= row[UP_LOG2-1:0];
			fc_q     <= col[UP_LOG2-1:0];
			height_q <= sample_height;
		end
	end

	// Neighbor issue counter
	logic             iss_act_q;
	logic [NBR_W-1:0] iss_q;
	logic             iss_last;

	assign iss_last = (query_q != OP_QUERY) || (iss_q == NBR_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_act_q <= 1'b0;
			iss_q     <= '0;
		end else if (in_acc) begin
			iss_act_q <= 1'b1;
			iss_q     <= '0;
		end else if (iss_act_q && !hold) begin
			iss_q <= iss_q + NBR_W'(1);
			if (iss_last) begin
				iss_act_q <= 1'b0;
			end
		end
	end

	// Address and weight of the current neighbor
	logic [IDX_W-1:0]  r_sel, c_sel;
	logic [FU_W-1:0]   wr_d, wc_d;
	logic [WT_W-1:0]   wt_d;
	logic [ADDR_W-1:0] addr_d;

	always_comb begin
		r_sel  = iss_q[0] ? r1_q : r0_q;
		c_sel  = iss_q[1] ? c1_q : c0_q;
		wr_d   = iss_q[0] ? FU_W'(fr_q) : FU_W'(UPSCALE) - FU_W'(fr_q);
		wc_d   = iss_q[1] ? FU_W'(fc_q) : FU_W'(UPSCALE) - FU_W'(fc_q);
		wt_d   = WT_W'(wr_d) * WT_W'(wc_d);
		addr_d = ADDR_W'(r_sel) * ADDR_W'(LOW_SIZE) + ADDR_W'(c_sel);
	end

	// Stage 1: address registered, RAM access
	// Stage 2: read data back, multiply-accumulate
	stg_t              ctl_s1, ctl_s2;
	logic [ADDR_W-1:0] addr_s1;
	logic [WT_W-1:0]   wt_s1, wt_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (!hold) begin
			ctl_s1.vld   <= iss_act_q;
			ctl_s1.last  <= iss_last;
			ctl_s1.query <= query_q;
			ctl_s1.wr    <= (query_q == OP_LOAD) && ld_ok_q;
			ctl_s2       <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!hold) begin
			addr_s1 <= addr_d;
			wt_s1   <= wt_d;
			wt_s2   <= wt_s1;
		end
	end

	// Grid memory
	logic                ram_we, ram_re;
	logic [HEIGHT_W-1:0] ram_rdata;

	assign ram_we = ctl_s1.vld && ctl_s1.wr;
	assign ram_re = ctl_s1.vld && ctl_s1.query && !hold;

	bu4x_ram #(
		.WIDTH (HEIGHT_W),
		.DEPTH (DEPTH)
	) u_grid (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_s1),
		.wdata (height_q),
		.re    (ram_re),
		.raddr (addr_s1),
		.rdata (ram_rdata)
	);

	// Weighted sum
	logic [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0] prod, sum;

	assign prod = ACC_W'(ram_rdata) * ACC_W'(wt_s2);
	assign sum  = acc_q + prod;
	assign fin  = ctl_s2.vld && ctl_s2.last && ctl_s2.query;
	assign hold = fin && out_valid && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl_s2.vld && ctl_s2.query && !hold) begin
			acc_q <= ctl_s2.last ? '0 : sum;
		end
	end

	// Release the core after the last access
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (in_acc) begin
			busy_q <= 1'b1;
		end else if (ctl_s2.vld && ctl_s2.last && !hold) begin
			busy_q <= 1'b0;
		end
	end

	// Output register
	logic out_valid_q;
	logic out_load;

	assign out_load  = fin && !hold;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			interpolated_height <= sum[2*UP_LOG2 +: HEIGHT_W];
		end
	end

	// Checks
	`BU4X_ASSERT_SAME(a_no_rw_overlap, clk, arst_n, ram_we, !ram_re, "grid read and write overlap")
	`BU4X_ASSERT_SAME(a_idle_empty, clk, arst_n, !busy_q, !iss_act_q && !ctl_s1.vld && !ctl_s2.vld, "pipeline active while idle")
	`BU4X_ASSERT_NEXT(a_hold_keeps, clk, arst_n, hold, ctl_s2.vld && ctl_s2.last && busy_q, "held result lost")
	`BU4X_ASSERT_NEXT(a_result_out, clk, arst_n, out_load, out_valid, "query finished without result")

endmodule
`default_nettype wire

### rtl/bu4x_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module bu4x_ram #(
	parameter int WIDTH = 13,
	parameter int DEPTH = 66049
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, data held while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire
